// ===== src/st_pkg.sv =====
// ---------------------------------------------------------------------------
// st_pkg: shared types and constants for the stereo tremolo
// Fixed-point constants, controller states, register map and the status
// word of the serial multiplier.
// ---------------------------------------------------------------------------
package st_pkg;

   // Q1.16 unity and field geometry
   localparam int Q16_SHIFT = 16;
   localparam int Q16_BITS  = 17;
   localparam logic [Q16_BITS-1:0] Q16_ONE = 17'd65536;

   // Q2.30 constants for building the sine table
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam int STEP_BITS = 24;

   // register reset values
   localparam logic                 ENABLE_RESET = 1'b1;
   localparam logic [STEP_BITS-1:0] STEP_RESET   = 24'd447392;
   localparam logic [Q16_BITS-1:0]  DEPTH_RESET  = 17'd52429;
   localparam logic [Q16_BITS-1:0]  MIX_RESET    = 17'd65536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE     = 2'd0,
      CSR_PHASE_STEP = 2'd1,
      CSR_DEPTH      = 2'd2,
      CSR_MIX        = 2'd3
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_INDEX = 7'b0000010,
      ST_MD    = 7'b0000100,
      ST_DIP   = 7'b0001000,
      ST_LEFT  = 7'b0010000,
      ST_RIGHT = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// ===== src/st_if.sv =====
// ---------------------------------------------------------------------------
// st_if: channel interfaces of the stereo tremolo
// Request (stereo frame in), response (stereo frame out) and register
// write channels, each with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface st_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface st_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface st_csr_if;
   logic                                valid;
   logic                                ready;
   logic [st_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [st_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/stereo_tremolo.sv =====
// ---------------------------------------------------------------------------
// stereo_tremolo: sine-LFO tremolo with dry/wet mix
// Scales each stereo frame by gain = 1 - mix*depth*(1-lfo) and steps the
// LFO phase accumulator while enabled; disabled, frames pass unchanged.
// ---------------------------------------------------------------------------
// A frame is taken only while the block is idle and is worked on alone.
// With tremolo enabled every product goes through one shared bit-serial
// multiplier, one bit a cycle, and the frame needs five of them (table
// index, mix*depth, dip, left, right), so the next frame is not taken
// until the last one is through. With tremolo disabled a frame goes
// straight to the done state. Results sit in an output register, so the
// next frame is accepted while a finished one still waits on the response
// channel. Register writes are never stalled and are meant to happen
// while no frame is in flight.
// ---------------------------------------------------------------------------
module stereo_tremolo #(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int SAMPLE_BITS      = 24
) (
   input  logic       clock,
   input  logic       reset,
   st_req_if.sink     req_ch,
   st_rsp_if.source   rsp_ch,
   st_csr_if.sink     csr_ch
);

   localparam int FracBits = PHASE_BITS - 2;
   localparam int AddrBits = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int QBits    = st_pkg::Q16_BITS;
   // multiplicand must hold the phase fraction, a sample or a Q1.16 value
   localparam int MulA0    = (FracBits + 1 > SAMPLE_BITS) ? FracBits + 1 : SAMPLE_BITS;
   localparam int MulA     = (MulA0 > QBits + 1) ? MulA0 : QBits + 1;
   localparam int MulB     = (AddrBits > QBits) ? AddrBits : QBits;
   localparam int ProdBits = MulA + MulB + 1;

   // ---- configuration registers ----
   logic                          enable_ff;
   logic [st_pkg::STEP_BITS-1:0]  step_ff;
   logic [QBits-1:0]              depth_ff;
   logic [QBits-1:0]              mix_ff;

   // ---- LFO and frame state ----
   logic [PHASE_BITS-1:0]         phase_ff;
   logic [PHASE_BITS-1:0]         phase_in;
   st_pkg::state_type             state_ff;
   st_pkg::state_type             state_in;
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic                          wet_ff;
   logic [QBits-1:0]              gain_ff;
   logic [AddrBits-1:0]           addr_ff;

   // ---- output register ----
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff;

   // ---- shared multiplier ----
   logic                          mul_start;
   logic signed [MulA-1:0]        mul_a;
   logic [MulB-1:0]               mul_b;
   st_pkg::mul_status_type        mul_sts;
   logic signed [ProdBits-1:0]    mul_prod;

   logic [QBits-1:0]              rom_q;

   // ---- datapath terms ----
   logic                          req_ready;
   logic                          req_accept;
   logic                          rsp_free;
   logic                          rsp_load;
   logic [FracBits-1:0]           frac;
   logic [1:0]                    quad;
   logic [AddrBits-1:0]           idx;
   logic [AddrBits-1:0]           addr_in;
   logic [QBits-1:0]              d_sat;
   logic [QBits-1:0]              m_sat;
   logic [QBits:0]                lfo_wide;
   logic [QBits-1:0]              lfo;
   logic [QBits-1:0]              md;
   logic [QBits-1:0]              gain_in;
   logic [SAMPLE_BITS-1:0]        scaled;

   assign req_ready  = (state_ff == st_pkg::ST_IDLE);
   assign req_accept = req_ch.valid & req_ready;
   assign rsp_free   = ~rsp_valid_ff | rsp_ch.ready;
   assign rsp_load   = (state_ff == st_pkg::ST_DONE) & rsp_free;

   assign req_ch.ready     = req_ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;

   // quadrant in the top two phase bits, the rest is the fraction
   assign frac = phase_ff[FracBits-1:0];
   assign quad = phase_ff[PHASE_BITS-1 -: 2];

   // index = floor(frac * DEPTH / 2^FracBits); odd quadrants read mirrored
   assign idx     = mul_prod[FracBits +: AddrBits];
   assign addr_in = quad[0] ? (AddrBits'(SINE_TABLE_DEPTH) - idx) : idx;

   // depth and mix above unity act as unity
   assign d_sat = depth_ff[QBits-1] ? st_pkg::Q16_ONE : depth_ff;
   assign m_sat = mix_ff[QBits-1] ? st_pkg::Q16_ONE : mix_ff;

   // lfo = (1 +/- |sin|) / 2
   assign lfo_wide = quad[1] ? ({1'b0, st_pkg::Q16_ONE} - {1'b0, rom_q})
                             : ({1'b0, st_pkg::Q16_ONE} + {1'b0, rom_q});
   assign lfo      = lfo_wide[QBits:1];

   // the mix*depth, dip and sample products are taken >> 16, low bits dropped (floor)
   assign md      = mul_prod[st_pkg::Q16_SHIFT +: QBits];
   assign gain_in = st_pkg::Q16_ONE - mul_prod[st_pkg::Q16_SHIFT +: QBits];
   assign scaled  = mul_prod[st_pkg::Q16_SHIFT +: SAMPLE_BITS];

   assign phase_in = phase_ff + PHASE_BITS'(step_ff);

   // ---- sequencer: each working state waits on one multiplication ----
   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         st_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (enable_ff) begin
                  mul_start = 1'b1;
                  mul_a     = MulA'(frac);
                  mul_b     = MulB'(SINE_TABLE_DEPTH);
                  state_in  = st_pkg::ST_INDEX;
               end else begin
                  state_in  = st_pkg::ST_DONE;
               end
            end
         end
         st_pkg::ST_INDEX: begin
            if (mul_sts.done) begin
               mul_start = 1'b1;
               mul_a     = MulA'(m_sat);
               mul_b     = MulB'(d_sat);
               state_in  = st_pkg::ST_MD;
            end
         end
         st_pkg::ST_MD: begin
            if (mul_sts.done) begin
               mul_start = 1'b1;
               mul_a     = MulA'(md);
               mul_b     = MulB'(st_pkg::Q16_ONE - lfo);
               state_in  = st_pkg::ST_DIP;
            end
         end
         st_pkg::ST_DIP: begin
            if (mul_sts.done) begin
               mul_start = 1'b1;
               mul_a     = MulA'(left_ff);
               mul_b     = MulB'(gain_in);
               state_in  = st_pkg::ST_LEFT;
            end
         end
         st_pkg::ST_LEFT: begin
            if (mul_sts.done) begin
               mul_start = 1'b1;
               mul_a     = MulA'(right_ff);
               mul_b     = MulB'(gain_ff);
               state_in  = st_pkg::ST_RIGHT;
            end
         end
         st_pkg::ST_RIGHT: begin
            if (mul_sts.done) begin
               state_in = st_pkg::ST_DONE;
            end
         end
         st_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = st_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = st_pkg::ST_IDLE;
         end
      endcase
   end

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= st_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         enable_ff    <= st_pkg::ENABLE_RESET;
         step_ff      <= st_pkg::STEP_RESET;
         depth_ff     <= st_pkg::DEPTH_RESET;
         mix_ff       <= st_pkg::MIX_RESET;
      end else begin
         state_ff <= state_in;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // phase steps once per wet frame, held while bypassed
         if (rsp_load && wet_ff) begin
            phase_ff <= phase_in;
         end

         if (csr_ch.valid) begin
            unique case (st_pkg::csr_index_type'(csr_ch.index))
               st_pkg::CSR_ENABLE:     enable_ff <= csr_ch.data[0];
               st_pkg::CSR_PHASE_STEP: step_ff   <= csr_ch.data[st_pkg::STEP_BITS-1:0];
               st_pkg::CSR_DEPTH:      depth_ff  <= csr_ch.data[QBits-1:0];
               st_pkg::CSR_MIX:        mix_ff    <= csr_ch.data[QBits-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---- frame payload ----
   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_ff  <= req_ch.left_in;
         right_ff <= req_ch.right_in;
         wet_ff   <= enable_ff;
      end
      if (state_ff == st_pkg::ST_INDEX && mul_sts.done) begin
         addr_ff <= addr_in;
      end
      if (state_ff == st_pkg::ST_DIP && mul_sts.done) begin
         gain_ff <= gain_in;
      end
      if (state_ff == st_pkg::ST_LEFT && mul_sts.done) begin
         left_ff <= scaled;
      end
      if (state_ff == st_pkg::ST_RIGHT && mul_sts.done) begin
         right_ff <= scaled;
      end
      if (rsp_load) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= right_ff;
      end
   end

   st_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .addr_i (addr_ff),
      .data_o (rom_q)
   );

   st_serial_mul #(
      .A_BITS (MulA),
      .B_BITS (MulB)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start_i  (mul_start),
      .a_i      (mul_a),
      .b_i      (mul_b),
      .status_o (mul_sts),
      .prod_o   (mul_prod)
   );

endmodule

// ===== src/st_sine_rom.sv =====
// ---------------------------------------------------------------------------
// st_sine_rom: quarter-wave sine table
// DEPTH+1 entries in Q1.16, built at elaboration from a truncating Q2.30
// Taylor series; registered read.
// ---------------------------------------------------------------------------
module st_sine_rom #(
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic [$clog2(DEPTH+1)-1:0]          addr_i,
   output logic [st_pkg::Q16_BITS-1:0]         data_o
);

   localparam int AddrBits = $clog2(DEPTH + 1);

   // sin(i * pi/2 / DEPTH), Horner form up to x^13, every product truncated
   function automatic logic [st_pkg::Q16_BITS-1:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] term;
      logic [63:0] s;
      int          k;
      x = (st_pkg::HALF_PI_Q30 * 64'(i)) / DEPTH;
      x2 = (x * x) >> 30;
      t = st_pkg::Q30_ONE;
      for (k = 0; k < 6; k++) begin
         p = (x2 * t) >> 30;
         case (k)
            0:       term = p / 156;
            1:       term = p / 110;
            2:       term = p / 72;
            3:       term = p / 42;
            4:       term = p / 20;
            default: term = p / 6;
         endcase
         t = (term >= st_pkg::Q30_ONE) ? 64'd0 : (st_pkg::Q30_ONE - term);
      end
      s = (x * t) >> 30;
      s = (s + 64'd8192) >> 14;
      if (s > 64'(st_pkg::Q16_ONE)) begin
         s = 64'(st_pkg::Q16_ONE);
      end
      return s[st_pkg::Q16_BITS-1:0];
   endfunction

   logic [st_pkg::Q16_BITS-1:0] rom_w [DEPTH+1];
   logic [st_pkg::Q16_BITS-1:0] data_ff;

   for (genvar i = 0; i <= DEPTH; i++) begin : g_entry
      localparam logic [st_pkg::Q16_BITS-1:0] Entry = sine_entry(i);
      assign rom_w[i] = Entry;
   end

   always_ff @(posedge clock) begin
      if (addr_i <= AddrBits'(DEPTH)) begin
         data_ff <= rom_w[addr_i];
      end else begin
         data_ff <= '0;
      end
   end

   assign data_o = data_ff;

endmodule

// ===== src/st_serial_mul.sv =====
// ---------------------------------------------------------------------------
// st_serial_mul: bit-serial signed-by-unsigned multiplier
// One multiplier bit per cycle, LSB first; full product after B_BITS steps.
// ---------------------------------------------------------------------------
module st_serial_mul #(
   parameter int A_BITS = 47,
   parameter int B_BITS = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_i,
   input  logic signed [A_BITS-1:0]      a_i,
   input  logic [B_BITS-1:0]             b_i,
   output st_pkg::mul_status_type        status_o,
   output logic signed [A_BITS+B_BITS:0] prod_o
);

   localparam int CntBits = $clog2(B_BITS);

   logic signed [A_BITS:0]   acc_ff;
   logic [B_BITS-1:0]        low_ff;
   logic signed [A_BITS-1:0] a_ff;
   logic [CntBits-1:0]       cnt_ff;
   logic                     running_ff;
   logic                     done_ff;

   logic signed [A_BITS:0]   addend;
   logic signed [A_BITS:0]   sum;

   // partial sum stays within twice |a|, so one guard bit is enough
   assign addend = low_ff[0] ? {a_ff[A_BITS-1], a_ff} : '0;
   assign sum    = acc_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else if (start_i) begin
         running_ff <= 1'b1;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else if (running_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(B_BITS - 1)) begin
            running_ff <= 1'b0;
            done_ff    <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         acc_ff <= '0;
         low_ff <= b_i;
         a_ff   <= a_i;
      end else if (running_ff) begin
         acc_ff <= {sum[A_BITS], sum[A_BITS:1]};
         low_ff <= {sum[0], low_ff[B_BITS-1:1]};
      end
   end

   assign status_o.busy = running_ff;
   assign status_o.done = done_ff;
   assign prod_o        = {acc_ff, low_ff};

endmodule

// ===== src/st_checker.sv =====
// ---------------------------------------------------------------------------
// st_checker: port-level checks for the stereo tremolo
// Watches the request and response handshakes of the top level.
// ---------------------------------------------------------------------------
module st_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_left,
   input logic [SAMPLE_BITS-1:0] rsp_right
);

   // no response beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one frame at a time: the request side closes after each beat
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a frame is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_right))
      else $error("response payload changed while stalled");

endmodule

bind stereo_tremolo st_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_st_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.left_out),
   .rsp_right (rsp_ch.right_out)
);

// ===== tb/stereo_tremolo_test.sv =====
// ---------------------------------------------------------------------------
// stereo_tremolo_test: self-checking bench for the stereo tremolo
// Drives stereo frames and register writes, predicts every output frame
// with an in-bench fixed-point tremolo and compares each response beat.
// ---------------------------------------------------------------------------
module stereo_tremolo_test;

   localparam int PHASE_W        = 32;
   localparam int TABLE_N        = 256;
   localparam int TABLE_ADDR_W   = $clog2(TABLE_N + 1);
   localparam int SAMPLE_W       = 24;
   localparam int FRAC_W         = PHASE_W - 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;    // idle margin before a register write
   localparam int DRAIN_CYCLES   = 200;  // idle margin before the final verdict
   localparam int RANDOM_FRAMES  = 1770;

   localparam bit [63:0] ONE_Q16 = 64'(st_pkg::Q16_ONE);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_frame_type;

   logic clock;
   logic reset;

   st_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   st_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_ch ();
   st_csr_if                           csr_ch ();

   stereo_tremolo #(
      .PHASE_BITS       (PHASE_W),
      .SINE_TABLE_DEPTH (TABLE_N),
      .SAMPLE_BITS      (SAMPLE_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // bench copy of the registers and the LFO phase
   logic                         cfg_enable = st_pkg::ENABLE_RESET;
   logic [st_pkg::STEP_BITS-1:0] cfg_step   = st_pkg::STEP_RESET;
   logic [st_pkg::Q16_BITS-1:0]  cfg_depth  = st_pkg::DEPTH_RESET;
   logic [st_pkg::Q16_BITS-1:0]  cfg_mix    = st_pkg::MIX_RESET;
   logic [PHASE_W-1:0]           lfo_phase  = '0;

   logic [st_pkg::Q16_BITS-1:0]  sine_q16 [0:TABLE_N];
   stereo_frame_type             expected_frames [$];
   stereo_frame_type             due_frame;

   int mismatches    = 0;
   int stall_count   = 0;
   int send_idle_pct = 18;
   int recv_idle_pct = 65;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Quarter-wave sine table: Horner-form Taylor series to x^13 in Q2.30,
   // every product truncated, then rounded half up to Q16 and capped at one.
   initial begin
      bit [63:0] divs [6];
      bit [63:0] x, x2, t, term, s;
      divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      for (int i = 0; i <= TABLE_N; i++) begin
         x  = (st_pkg::HALF_PI_Q30 * 64'(i)) / 64'(TABLE_N);
         x2 = (x * x) >> 30;
         t  = st_pkg::Q30_ONE;
         for (int k = 0; k < 6; k++) begin
            term = ((x2 * t) >> 30) / divs[k];
            t    = (term >= st_pkg::Q30_ONE) ? 64'd0 : (st_pkg::Q30_ONE - term);
         end
         s = (x * t) >> 30;
         s = (s + 64'd8192) >> 14;
         if (s > ONE_Q16) s = ONE_Q16;
         sine_q16[i] = s[st_pkg::Q16_BITS-1:0];
      end
   end

   // Works out one output frame and, with tremolo enabled, steps the LFO, as
   // the block does for an accepted beat.
   function automatic stereo_frame_type tremolo_frame(stereo_frame_type din);
      stereo_frame_type dout;
      logic [1:0]       quadrant;
      bit [63:0]        frac, idx, s_mag, lfo, d, m, md, dip, gain;
      longint           prod;
      if (!cfg_enable) return din;   // bypass: samples through, phase held
      quadrant = lfo_phase[PHASE_W-1 -: 2];
      frac     = 64'(lfo_phase[FRAC_W-1:0]);
      idx      = (frac * 64'(TABLE_N)) >> FRAC_W;
      if (idx > 64'(TABLE_N)) idx = 64'(TABLE_N);
      if (quadrant[0]) idx = 64'(TABLE_N) - idx;
      s_mag = 64'(sine_q16[idx[TABLE_ADDR_W-1:0]]);
      lfo   = quadrant[1] ? ((ONE_Q16 - s_mag) >> 1) : ((ONE_Q16 + s_mag) >> 1);
      // depth and mix above one act as one
      d    = (cfg_depth > st_pkg::Q16_ONE) ? ONE_Q16 : 64'(cfg_depth);
      m    = (cfg_mix > st_pkg::Q16_ONE) ? ONE_Q16 : 64'(cfg_mix);
      md   = (m * d) >> 16;
      dip  = (md * (ONE_Q16 - lfo)) >> 16;
      gain = ONE_Q16 - dip;
      // arithmetic shift floors, as dropping the low bits does
      prod       = longint'(din.left) * longint'(gain);
      prod       = prod >>> 16;
      dout.left  = prod[SAMPLE_W-1:0];
      prod       = longint'(din.right) * longint'(gain);
      prod       = prod >>> 16;
      dout.right = prod[SAMPLE_W-1:0];
      lfo_phase  = lfo_phase + PHASE_W'(cfg_step);   // wraps modulo a full turn
      return dout;
   endfunction

   // --- response side: random back-pressure and the beat checker ---------

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: left %0d right %0d",
                        rsp_ch.left_out, rsp_ch.right_out);
         end else begin
            due_frame = expected_frames.pop_front();
            if (rsp_ch.left_out !== due_frame.left || rsp_ch.right_out !== due_frame.right) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch: left exp %0d got %0d, right exp %0d got %0d",
                           due_frame.left, rsp_ch.left_out,
                           due_frame.right, rsp_ch.right_out);
            end
         end
      end
   end

   // Watchdog: any accepted beat on any channel resets the stall count.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // --- shared stimulus tasks ----------------------------------------------

   // One frame beat. Valid stays high after acceptance so back-to-back beats
   // need no second assignment in the same step; the next call drops it while idling, as settle does.
   task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                             input logic signed [SAMPLE_W-1:0] right);
      stereo_frame_type beat;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.left_in  <= left;
      req_ch.right_in <= right;
      do @(posedge clock); while (!req_ch.ready);
      beat.left  = left;
      beat.right = right;
      expected_frames.push_back(tremolo_frame(beat));
   endtask

   // Hold the sender off until every frame has come back, then a margin.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input st_pkg::csr_index_type idx,
                                 input logic [st_pkg::CSR_DATA_BITS-1:0] word);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= word;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         st_pkg::CSR_ENABLE:     cfg_enable = word[0];
         st_pkg::CSR_PHASE_STEP: cfg_step   = word[st_pkg::STEP_BITS-1:0];
         st_pkg::CSR_DEPTH:      cfg_depth  = word[st_pkg::Q16_BITS-1:0];
         st_pkg::CSR_MIX:        cfg_mix    = word[st_pkg::Q16_BITS-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
         1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
         2:       return SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Q1.16 register word, upper junk bits included to exercise masking.
   function automatic logic [st_pkg::CSR_DATA_BITS-1:0] random_q16();
      logic [st_pkg::CSR_DATA_BITS-1:0] word;
      word = st_pkg::CSR_DATA_BITS'($urandom);
      case ($urandom_range(4))
         0:       word[st_pkg::Q16_BITS-1:0] = '0;
         1:       word[st_pkg::Q16_BITS-1:0] = st_pkg::Q16_ONE;
         2:       word[st_pkg::Q16_BITS-1:0] = st_pkg::Q16_BITS'($urandom_range(131071, 65537));
         default: word[st_pkg::Q16_BITS-1:0] = st_pkg::Q16_BITS'($urandom_range(65536));
      endcase
      return word;
   endfunction

   // --- tests --------------------------------------------------------------

   // Reset values: default depth, full mix, default step.
   task automatic test_reset_defaults();
      send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(-24'sh800000, 24'sh7FFFFF);
      send_frame(24'sh000000, 24'sh000000);
      send_frame(-24'sh000001, 24'sh000001);
      send_frame(24'sh555555, -24'sh2AAAAB);
   endtask

   // Full depth and mix at the fastest step, then no depth, then no mix.
   task automatic test_full_swing();
      settle();
      write_register(st_pkg::CSR_DEPTH, 24'd65536);
      write_register(st_pkg::CSR_MIX, 24'd65536);
      write_register(st_pkg::CSR_PHASE_STEP, 24'hFFFFFF);
      repeat (4) send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(-24'sh000001, 24'sh000001);
      settle();
      write_register(st_pkg::CSR_DEPTH, 24'd0);
      send_frame(24'sh7FFFFF, -24'sh800000);
      settle();
      write_register(st_pkg::CSR_DEPTH, 24'd65536);
      write_register(st_pkg::CSR_MIX, 24'd0);
      send_frame(-24'sh800000, 24'sh7FFFFF);
   endtask

   // Depth and mix above one saturate; upper data bits must be dropped.
   task automatic test_saturation();
      settle();
      write_register(st_pkg::CSR_DEPTH, 24'h1FFFFF);
      write_register(st_pkg::CSR_MIX, 24'd65537);
      send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(24'sh123456, -24'sh123456);
      settle();
      write_register(st_pkg::CSR_DEPTH, 24'hFE0000 | 24'd40000);
      send_frame(24'sh400000, -24'sh400000);
   endtask

   // Bypass: frames through untouched and phase frozen across the gap.
   task automatic test_bypass();
      settle();
      write_register(st_pkg::CSR_ENABLE, 24'hFFFFFE);
      send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(-24'sh000001, 24'sh000000);
      send_frame(24'sh3C5A96, -24'sh3C5A96);
      settle();
      write_register(st_pkg::CSR_ENABLE, 24'h000003);
      send_frame(24'sh7FFFFF, -24'sh800000);
      send_frame(-24'sh800000, 24'sh7FFFFF);
   endtask

   // Random bursts, settings reshuffled between bursts; the idle pattern
   // runs sender-light, then receiver-light, then none at all.
   task automatic test_random_traffic();
      int sent;
      int burst;
      logic [st_pkg::CSR_DATA_BITS-1:0] word;
      for (int stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 18 : (stage == 1) ? 65 : 0;
         recv_idle_pct = (stage == 0) ? 65 : (stage == 1) ? 18 : 0;
         sent = 0;
         while (sent < RANDOM_FRAMES / 3) begin
            settle();
            word    = st_pkg::CSR_DATA_BITS'($urandom);
            word[0] = ($urandom_range(99) < 80);
            write_register(st_pkg::CSR_ENABLE, word);
            case ($urandom_range(5))
               0:       word = '0;
               1:       word = 24'hFFFFFF;
               2:       word = st_pkg::CSR_DATA_BITS'($urandom_range(4096));
               3:       word = 24'h800000;
               default: word = st_pkg::CSR_DATA_BITS'($urandom);
            endcase
            write_register(st_pkg::CSR_PHASE_STEP, word);
            write_register(st_pkg::CSR_DEPTH, random_q16());
            write_register(st_pkg::CSR_MIX, random_q16());
            burst = $urandom_range(20, 60);
            repeat (burst) send_frame(random_sample(), random_sample());
            sent += burst;
         end
      end
   endtask

   // --- sequence -----------------------------------------------------------

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.left_in  <= '0;
      req_ch.right_in <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= st_pkg::CSR_ENABLE;
      csr_ch.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_swing();
      test_saturation();
      test_bypass();
      test_random_traffic();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
src/st_pkg.sv
src/st_if.sv
src/st_sine_rom.sv
src/st_serial_mul.sv
src/stereo_tremolo.sv
src/st_checker.sv
tb/stereo_tremolo_test.sv
